/* rtl/lpbr_pkg.sv */
`default_nettype none

package lpbr_pkg;

    localparam int ID_W   = 22;
    localparam int BYTE_W = 8;

    // code of one result word
    typedef enum logic [2:0] {
        KIND_ABSORBED = 3'd0,
        KIND_GRANTED  = 3'd1,
        KIND_REFUSED  = 3'd2,
        KIND_BYTE     = 3'd3,
        KIND_LAST     = 3'd4,
        KIND_EMPTY    = 3'd5
    } t_kind;

    // one signal event as it travels from the queue to the session logic
    typedef struct packed {
        logic            bit_value;
        logic [ID_W-1:0] sender_id;
    } t_item;

endpackage

`default_nettype wire

/* rtl/length_prefixed_bit_receiver.sv */
// Length-prefixed bit receiver.
// Slave stream: one word per signal event, sender id and one data bit.
// The first event while idle opens a session for its sender (granted);
// events of other senders are refused while it is open. The owner's bits,
// lsb first, give a LENGTH_BITS length and then the message bytes.
// Master stream: exactly one result word per accepted event, in order;
// kind in tuser, reply target and byte in tdata.
// Each accepted event waits in the queue; its result is held in the output
// register, which drives tvalid on the master side.
// Throughput: one word per cycle unless the master side stalls, set by the
// session register update in the back end; a two-entry queue is in front.
// Reset (i_rst_n low at a clock edge) empties the queue and the output
// register and closes any session.
// When the master side stalls, the output register holds its word, the
// back end stops, and the queue takes up to two more words before
// o_s_axis_tready drops.
`default_nettype none

module length_prefixed_bit_receiver #(
    parameter int LENGTH_BITS = 32
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [21:0] sender_id, [22] bit_value, [23] zero
    input  wire  [23:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  wire         i_m_axis_tready,
    // [21:0] reply_target, [29:22] data_byte, [31:30] zero
    output logic [31:0] o_m_axis_tdata,
    // [2:0] result_kind
    output logic [2:0]  o_m_axis_tuser
);

    lpbr_pkg::t_item                in_item;
    lpbr_pkg::t_item                q_item;
    logic                           q_valid;
    logic                           q_ready;
    lpbr_pkg::t_kind                kind;
    logic [lpbr_pkg::ID_W-1:0]      target;
    logic [lpbr_pkg::BYTE_W-1:0]    data_byte;

    assign in_item.sender_id = i_s_axis_tdata[21:0];
    assign in_item.bit_value = i_s_axis_tdata[22];

    lpbr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .i_in_item   (in_item),
        .o_out_valid (q_valid),
        .i_out_ready (q_ready),
        .o_out_item  (q_item)
    );

    lpbr_core #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (q_valid),
        .o_in_ready  (q_ready),
        .i_in_item   (q_item),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_kind      (kind),
        .o_target    (target),
        .o_byte      (data_byte)
    );

    assign o_m_axis_tdata = {2'b00, data_byte, target};
    assign o_m_axis_tuser = kind;

    // reset leaves no result pending
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

    // only byte results carry a byte
    a_byte_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && kind != lpbr_pkg::KIND_BYTE && kind != lpbr_pkg::KIND_LAST)
        |-> (data_byte == '0))
        else $error("data byte set on a non-byte result");

    // only grant and refusal carry a reply target
    a_target_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && kind != lpbr_pkg::KIND_GRANTED
            && kind != lpbr_pkg::KIND_REFUSED)
        |-> (target == '0))
        else $error("reply target set on a data result");

    // a queued event is taken whenever the output register is free
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !o_m_axis_tvalid) |=> o_m_axis_tvalid)
        else $error("back end did not take a queued event");

endmodule

`default_nettype wire

/* rtl/lpbr_queue.sv */
`default_nettype none

// two-entry queue between the input channel and the session logic
module lpbr_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  lpbr_pkg::t_item     i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output lpbr_pkg::t_item     o_out_item
);

    lpbr_pkg::t_item r_mem [2];
    logic            r_wr_ptr;
    logic            r_rd_ptr;
    logic [1:0]      r_count;
    logic            n_wr_ptr;
    logic            n_rd_ptr;
    logic [1:0]      n_count;
    logic            push;
    logic            pop;

    assign o_in_ready  = (r_count != 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_item  = r_mem[r_rd_ptr];
    assign push        = i_in_valid && o_in_ready;
    assign pop         = o_out_valid && i_out_ready;

    always_comb begin
        n_wr_ptr = push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/lpbr_core.sv */
`default_nettype none

// session state, header and byte assembly, registered result
module lpbr_core #(
    parameter int LENGTH_BITS = 32
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  lpbr_pkg::t_item              i_in_item,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output lpbr_pkg::t_kind              o_kind,
    output logic [lpbr_pkg::ID_W-1:0]    o_target,
    output logic [lpbr_pkg::BYTE_W-1:0]  o_byte
);

    localparam int HDR_W = $clog2(LENGTH_BITS);
    localparam logic [HDR_W-1:0] HDR_LAST = HDR_W'(LENGTH_BITS - 1);

    logic                         r_open;
    logic [lpbr_pkg::ID_W-1:0]    r_owner;
    logic                         r_in_hdr;
    logic [LENGTH_BITS-1:0]       r_len;
    logic [HDR_W-1:0]             r_hdr_cnt;
    logic [2:0]                   r_bit_cnt;
    logic [LENGTH_BITS-1:0]       r_bytes;
    logic [lpbr_pkg::BYTE_W-1:0]  r_part;

    logic                         n_open;
    logic [lpbr_pkg::ID_W-1:0]    n_owner;
    logic                         n_in_hdr;
    logic [LENGTH_BITS-1:0]       n_len;
    logic [HDR_W-1:0]             n_hdr_cnt;
    logic [2:0]                   n_bit_cnt;
    logic [LENGTH_BITS-1:0]       n_bytes;
    logic [lpbr_pkg::BYTE_W-1:0]  n_part;

    logic                         r_out_valid;
    lpbr_pkg::t_kind              r_kind;
    logic [lpbr_pkg::ID_W-1:0]    r_target;
    logic [lpbr_pkg::BYTE_W-1:0]  r_byte;

    lpbr_pkg::t_kind              res_kind;
    logic [lpbr_pkg::ID_W-1:0]    res_target;
    logic [lpbr_pkg::BYTE_W-1:0]  res_byte;
    logic [lpbr_pkg::BYTE_W-1:0]  full_byte;
    logic                         fire;
    logic                         close;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign fire       = i_in_valid && o_in_ready;
    assign full_byte  = {i_in_item.bit_value, r_part[lpbr_pkg::BYTE_W-1:1]};

    always_comb begin
        n_open     = r_open;
        n_owner    = r_owner;
        n_in_hdr   = r_in_hdr;
        n_len      = r_len;
        n_hdr_cnt  = r_hdr_cnt;
        n_bit_cnt  = r_bit_cnt;
        n_bytes    = r_bytes;
        n_part     = r_part;
        res_kind   = lpbr_pkg::KIND_ABSORBED;
        res_target = '0;
        res_byte   = '0;
        close      = 1'b0;
        if (!r_open) begin
            // opening event: its bit is dropped
            close      = 1'b1;
            res_kind   = lpbr_pkg::KIND_GRANTED;
            res_target = i_in_item.sender_id;
        end else if (i_in_item.sender_id != r_owner) begin
            res_kind   = lpbr_pkg::KIND_REFUSED;
            res_target = i_in_item.sender_id;
        end else if (r_in_hdr) begin
            // lsb first: shift in from the top
            n_len     = {i_in_item.bit_value, r_len[LENGTH_BITS-1:1]};
            n_hdr_cnt = r_hdr_cnt + HDR_W'(1);
            if (r_hdr_cnt == HDR_LAST) begin
                n_in_hdr = 1'b0;
                if (n_len == '0) begin
                    close    = 1'b1;
                    res_kind = lpbr_pkg::KIND_EMPTY;
                end
            end
        end else begin
            n_part    = full_byte;
            n_bit_cnt = r_bit_cnt + 3'd1;
            if (r_bit_cnt == 3'd7) begin
                res_byte = full_byte;
                n_part   = '0;
                n_bytes  = r_bytes + LENGTH_BITS'(1);
                if (n_bytes == r_len) begin
                    close    = 1'b1;
                    res_kind = lpbr_pkg::KIND_LAST;
                end else begin
                    res_kind = lpbr_pkg::KIND_BYTE;
                end
            end
        end
        if (close) begin
            n_open    = !r_open;
            n_owner   = r_open ? '0 : i_in_item.sender_id;
            n_in_hdr  = 1'b1;
            n_len     = '0;
            n_hdr_cnt = '0;
            n_bit_cnt = '0;
            n_bytes   = '0;
            n_part    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_owner   <= '0;
            r_in_hdr  <= 1'b1;
            r_len     <= '0;
            r_hdr_cnt <= '0;
            r_bit_cnt <= '0;
            r_bytes   <= '0;
            r_part    <= '0;
        end else if (fire) begin
            r_open    <= n_open;
            r_owner   <= n_owner;
            r_in_hdr  <= n_in_hdr;
            r_len     <= n_len;
            r_hdr_cnt <= n_hdr_cnt;
            r_bit_cnt <= n_bit_cnt;
            r_bytes   <= n_bytes;
            r_part    <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_kind   <= res_kind;
            r_target <= res_target;
            r_byte   <= res_byte;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_target    = r_target;
    assign o_byte      = r_byte;

endmodule

`default_nettype wire

/* tb/sv/length_prefixed_bit_receiver_test.sv */
`default_nettype none

module length_prefixed_bit_receiver_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_BITS    = 32;
    localparam int EVENT_COUNT = 950;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [lpbr_pkg::ID_W-1:0] ID_MAX = {lpbr_pkg::ID_W{1'b1}};

    typedef struct packed {
        lpbr_pkg::t_kind             kind;
        logic [lpbr_pkg::ID_W-1:0]   target;
        logic [lpbr_pkg::BYTE_W-1:0] data;
    } t_reply;

    typedef struct {
        logic [lpbr_pkg::ID_W-1:0] sender;
        logic                      bit_val;
        int                        reps;
        t_reply                    want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [23:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [2:0]  o_m_axis_tuser;

    length_prefixed_bit_receiver #(.LENGTH_BITS(HDR_BITS)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    // session state as the receiver should hold it
    logic                        rx_open;
    logic [lpbr_pkg::ID_W-1:0]   rx_owner;
    logic                        rx_in_hdr;
    logic [31:0]                 rx_len;
    logic [5:0]                  rx_hdr_cnt;
    int                          rx_bit_cnt;
    logic [31:0]                 rx_bytes;
    logic [lpbr_pkg::BYTE_W-1:0] rx_acc;

    t_reply replies_due[$];
    int     mismatches;
    int     events_sent;
    int     cycles;
    int     kinds_seen[6];
    logic   tx_steady;
    logic   rx_steady;

    // owner opens with a max id, foreigners get refused, then the first
    // seventeen header bits give a length of one
    t_row dir_rows[7] = '{
        '{ID_MAX,     1'b1, 1,  '{lpbr_pkg::KIND_GRANTED,  ID_MAX,     8'h00}},
        '{22'h000000, 1'b1, 1,  '{lpbr_pkg::KIND_REFUSED,  22'h000000, 8'h00}},
        '{22'h3FFFFE, 1'b0, 1,  '{lpbr_pkg::KIND_REFUSED,  22'h3FFFFE, 8'h00}},
        '{ID_MAX,     1'b1, 1,  '{lpbr_pkg::KIND_ABSORBED, 22'h000000, 8'h00}},
        '{22'h155555, 1'b1, 1,  '{lpbr_pkg::KIND_REFUSED,  22'h155555, 8'h00}},
        '{22'h2AAAAA, 1'b0, 1,  '{lpbr_pkg::KIND_REFUSED,  22'h2AAAAA, 8'h00}},
        '{ID_MAX,     1'b0, 16, '{lpbr_pkg::KIND_ABSORBED, 22'h000000, 8'h00}}
    };

    function automatic void close_session();
        rx_open    = 1'b0;
        rx_owner   = '0;
        rx_in_hdr  = 1'b1;
        rx_len     = '0;
        rx_hdr_cnt = '0;
        rx_bit_cnt = 0;
        rx_bytes   = '0;
        rx_acc     = '0;
    endfunction

    function automatic t_reply next_reply(input logic [lpbr_pkg::ID_W-1:0] sender,
                                          input logic bv);
        t_reply r;
        r = '{lpbr_pkg::KIND_ABSORBED, '0, '0};
        if (!rx_open) begin
            close_session();
            rx_open  = 1'b1;
            rx_owner = sender;
            r.kind   = lpbr_pkg::KIND_GRANTED;
            r.target = sender;
        end else if (sender != rx_owner) begin
            r.kind   = lpbr_pkg::KIND_REFUSED;
            r.target = sender;
        end else if (rx_in_hdr) begin
            rx_len     = rx_len | (32'(bv) << rx_hdr_cnt[4:0]);
            rx_hdr_cnt = rx_hdr_cnt + 6'd1;
            if (rx_hdr_cnt >= HDR_BITS) begin
                rx_in_hdr = 1'b0;
                if (rx_len == 0) begin
                    close_session();
                    r.kind = lpbr_pkg::KIND_EMPTY;
                end
            end
        end else begin
            rx_acc     = rx_acc | (lpbr_pkg::BYTE_W'(bv) << rx_bit_cnt);
            rx_bit_cnt = rx_bit_cnt + 1;
            if (rx_bit_cnt >= lpbr_pkg::BYTE_W) begin
                r.data     = rx_acc;
                rx_bit_cnt = 0;
                rx_acc     = '0;
                rx_bytes   = rx_bytes + 32'd1;
                if (rx_bytes == rx_len) begin
                    close_session();
                    r.kind = lpbr_pkg::KIND_LAST;
                end else begin
                    r.kind = lpbr_pkg::KIND_BYTE;
                end
            end
        end
        return r;
    endfunction

    function automatic logic [lpbr_pkg::ID_W-1:0] pick_id();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ID_MAX;
            default: return lpbr_pkg::ID_W'($urandom_range(0, 32'h3FFFFF));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_event(input logic [lpbr_pkg::ID_W-1:0] sender, input logic bv,
                              input logic use_want, input t_reply want);
        int     gap;
        t_reply r;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {1'b0, lpbr_pkg::t_item'{bit_value: bv, sender_id: sender}};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = next_reply(sender, bv);
        replies_due.push_back(use_want ? want : r);
        events_sent++;
        @(negedge i_clk);
    endtask

    // keeps driving until the session closes or cap events went out
    task automatic run_session(input logic [31:0] len, input int cap);
        int                        n;
        int                        data_mode;
        logic                      bv;
        logic [lpbr_pkg::ID_W-1:0] id;
        data_mode = $urandom_range(0, 3);
        if (!rx_open)
            send_event(pick_id(), 1'($urandom_range(0, 1)), 1'b0, '0);
        n = 0;
        while (rx_open && n < cap) begin
            if ($urandom_range(0, 9) == 0) begin
                id = pick_id();
                if (id == rx_owner)
                    id[0] = ~id[0];
                send_event(id, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
                if (rx_in_hdr)
                    bv = len[rx_hdr_cnt[4:0]];
                else if (data_mode == 0)
                    bv = 1'b1;
                else if (data_mode == 1)
                    bv = 1'b0;
                else
                    bv = 1'($urandom_range(0, 1));
                send_event(rx_owner, bv, 1'b0, '0);
            end
            n++;
        end
    endtask

    task automatic wait_replies();
        i_s_axis_tvalid = 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic void log_mismatch(input string why, input t_reply want);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected kind %0d target %h byte %h, got kind %0d target %h byte %h",
                     why, want.kind, want.target, want.data, o_m_axis_tuser,
                     o_m_axis_tdata[lpbr_pkg::ID_W-1:0],
                     o_m_axis_tdata[lpbr_pkg::ID_W +: lpbr_pkg::BYTE_W]);
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, replies_due.size());
            $display("length_prefixed_bit_receiver verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin : check_words
        t_reply want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (replies_due.size() == 0) begin
                log_mismatch("word with nothing due", '0);
            end else begin
                want = replies_due.pop_front();
                kinds_seen[want.kind]++;
                if (o_m_axis_tuser !== want.kind
                        || o_m_axis_tdata[lpbr_pkg::ID_W-1:0] !== want.target
                        || o_m_axis_tdata[lpbr_pkg::ID_W +: lpbr_pkg::BYTE_W] !== want.data)
                    log_mismatch("word mismatch", want);
            end
        end
    end

    // result side: random stall before each word, or none in steady stretches
    initial begin : drain_results
        int stall;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n);
        forever begin
            stall = rx_steady ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int   r;
        logic held;
        logic [31:0] len;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        tx_steady       = 1'b0;
        rx_steady       = 1'b0;
        mismatches      = 0;
        events_sent     = 0;
        cycles          = 0;
        held            = 1'b0;
        foreach (kinds_seen[k])
            kinds_seen[k] = 0;
        close_session();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            repeat (dir_rows[i].reps)
                send_event(dir_rows[i].sender, dir_rows[i].bit_val, 1'b1, dir_rows[i].want);

        // mostly well-formed sessions of short messages, foreign words mixed in
        while (events_sent < EVENT_COUNT) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 9);
            if (r < 2)
                len = 0;
            else if (r < 8)
                len = $urandom_range(1, 3);
            else
                len = $urandom_range(4, 8);
            run_session(len, 400);
            if (!held && events_sent > EVENT_COUNT / 2) begin
                wait_replies();
                held = 1'b1;
            end
        end

        // all-ones length never completes, just push a few bytes through
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        run_session(32'hFFFF_FFFF, 60);

        wait_replies();
        repeat (8) @(posedge i_clk);
        $display("%0d events: %0d grants, %0d refusals, %0d absorbed bits",
                 events_sent, kinds_seen[lpbr_pkg::KIND_GRANTED],
                 kinds_seen[lpbr_pkg::KIND_REFUSED], kinds_seen[lpbr_pkg::KIND_ABSORBED]);
        $display("%0d bytes mid-message, %0d closing bytes, %0d empty messages",
                 kinds_seen[lpbr_pkg::KIND_BYTE], kinds_seen[lpbr_pkg::KIND_LAST],
                 kinds_seen[lpbr_pkg::KIND_EMPTY]);
        if (mismatches == 0)
            $display("length_prefixed_bit_receiver verification clean");
        else
            $display("length_prefixed_bit_receiver verification failed");
        $finish;
    end

endmodule

`default_nettype wire
